/* hw/rtl/unordered_value_table_top_defines.svh */
// Assertion macros shared by the unordered value table RTL.
`ifndef UNORDERED_VALUE_TABLE_TOP_DEFINES_SVH
`define UNORDERED_VALUE_TABLE_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define UVT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define UVT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/uvt_pkg.sv */
// Shared constants and types of the unordered value table.
package uvt_pkg;

	localparam int DEF_TABLE_DEPTH = 16;
	localparam int DEF_VALUE_BITS  = 32;

	localparam int CMD_W         = 2;
	localparam int VALUE_W       = 32;
	localparam int STATUS_W      = 2;
	localparam int ENTRY_COUNT_W = 5;
	localparam int M_TDATA_W     = 8;

	typedef logic [CMD_W-1:0]    cmd_t;
	typedef logic [STATUS_W-1:0] status_t;

	localparam cmd_t CMD_INSERT = 2'd0;
	localparam cmd_t CMD_SEARCH = 2'd1;
	localparam cmd_t CMD_DELETE = 2'd2;

	localparam status_t STAT_DONE    = 2'd0;
	localparam status_t STAT_MISSING = 2'd1;
	localparam status_t STAT_FULL    = 2'd2;

	// Strobes from the control sequencer to the entry memory.
	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} ram_ctl_t;

endpackage

/* hw/rtl/uvt_ram.sv */
// Entry memory of the unordered value table: one write port, one registered read port.
module uvt_ram #(
	parameter int DEPTH  = 16,
	parameter int WIDTH  = 32,
	parameter int ADDR_W = 4
) (
	input  logic                 clk,
	input  uvt_pkg::ram_ctl_t    ctl,
	input  logic [ADDR_W-1:0]    wr_addr,
	input  logic [WIDTH-1:0]     wr_data,
	input  logic [ADDR_W-1:0]    rd_addr,
	output logic [WIDTH-1:0]     rd_data
);
	import uvt_pkg::*;

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* hw/rtl/unordered_value_table_top.sv */
// Top level of the unordered value table: command sequencer, live count and result register.
//
// Each request carries a command in s_tuser (insert, search, delete) and a value in s_tdata,
// and yields one response with a status and the live entry count. Requests are handled one at
// a time. Search and delete on a non-empty table scan the entry memory, which has one registered
// read port, one entry per cycle from index 0. The response is loaded into the output register as
// the sequencer leaves its finish state for idle, where the next request can be accepted. The
// sequencer holds in its finish state for as long as an earlier response still waits unaccepted in
// the output register.
module unordered_value_table_top #(
	parameter int TABLE_DEPTH = uvt_pkg::DEF_TABLE_DEPTH,
	parameter int VALUE_BITS  = uvt_pkg::DEF_VALUE_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [uvt_pkg::VALUE_W-1:0]   s_tdata,  // [31:0] value
	input  logic [uvt_pkg::CMD_W-1:0]     s_tuser,  // [1:0] command
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [uvt_pkg::M_TDATA_W-1:0] m_tdata   // [1:0] status, [6:2] entry_count
);
	import uvt_pkg::*;

	`include "unordered_value_table_top_defines.svh"

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	localparam logic [2:0] FSM_IDLE   = 3'd0;
	localparam logic [2:0] FSM_SCAN   = 3'd1;
	localparam logic [2:0] FSM_SWAP   = 3'd2;
	localparam logic [2:0] FSM_FINISH = 3'd3;

	logic [2:0]              state_q;
	logic [CNT_W-1:0]        count_q;
	cmd_t                    cmd_q;
	logic [VALUE_BITS-1:0]   value_q;
	logic [IDX_W-1:0]        chk_q;
	status_t                 status_q;
	logic                    m_tvalid_q;
	status_t                 out_status_q;
	logic [ENTRY_COUNT_W-1:0] out_count_q;

	ram_ctl_t                ram_ctl;
	logic [IDX_W-1:0]        wr_addr;
	logic [VALUE_BITS-1:0]   wr_data;
	logic [IDX_W-1:0]        rd_addr;
	logic [VALUE_BITS-1:0]   rd_data;

	logic                    accept;
	cmd_t                    cmd_in;
	logic [VALUE_BITS-1:0]   value_in;
	logic                    full;
	logic                    hit;
	logic [CNT_W-1:0]        nxt_chk;
	logic                    more;
	logic [IDX_W-1:0]        last_idx;
	logic [CNT_W+ENTRY_COUNT_W-1:0] count_ext;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == FSM_IDLE);
	assign cmd_in   = s_tuser;
	assign value_in = VALUE_BITS'(s_tdata);
	assign full     = (count_q >= CNT_W'(TABLE_DEPTH));
	assign hit      = (rd_data == value_q);
	assign nxt_chk  = CNT_W'(chk_q) + CNT_W'(1);
	assign more     = (nxt_chk < count_q);
	assign last_idx = IDX_W'(count_q - CNT_W'(1));
	// The reported count is the live count reduced to the five-bit field.
	assign count_ext = (CNT_W + ENTRY_COUNT_W)'(count_q);

	always_comb begin
		ram_ctl = '0;
		wr_addr = IDX_W'(count_q);
		wr_data = value_in;
		rd_addr = '0;
		unique case (state_q)
			FSM_IDLE: begin
				if (accept && cmd_in == CMD_INSERT && !full) begin
					ram_ctl.wr_en = 1'b1;
				end
				if (accept && (cmd_in == CMD_SEARCH || cmd_in == CMD_DELETE)
						&& count_q != '0) begin
					ram_ctl.rd_en = 1'b1;
				end
			end
			FSM_SCAN: begin
				if (hit && cmd_q == CMD_DELETE) begin
					ram_ctl.rd_en = 1'b1;
					rd_addr = last_idx;
				end else if (!hit && more) begin
					ram_ctl.rd_en = 1'b1;
					rd_addr = IDX_W'(nxt_chk);
				end
			end
			FSM_SWAP: begin
				// The last live entry fills the hole left by the deleted one.
				ram_ctl.wr_en = 1'b1;
				wr_addr = chk_q;
				wr_data = rd_data;
			end
			default: begin
			end
		endcase
	end

	uvt_ram #(
		.DEPTH  (TABLE_DEPTH),
		.WIDTH  (VALUE_BITS),
		.ADDR_W (IDX_W)
	) u_ram (
		.clk     (clk),
		.ctl     (ram_ctl),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= FSM_IDLE;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == FSM_FINISH && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				FSM_IDLE: begin
					if (accept) begin
						state_q <= FSM_FINISH;
						if (cmd_in == CMD_INSERT) begin
							if (!full) begin
								count_q <= count_q + CNT_W'(1);
							end
						end else if (cmd_in == CMD_SEARCH || cmd_in == CMD_DELETE) begin
							if (count_q != '0) begin
								state_q <= FSM_SCAN;
							end
						end
					end
				end
				FSM_SCAN: begin
					if (hit) begin
						state_q <= (cmd_q == CMD_DELETE) ? FSM_SWAP : FSM_FINISH;
					end else if (!more) begin
						state_q <= FSM_FINISH;
					end
				end
				FSM_SWAP: begin
					count_q <= count_q - CNT_W'(1);
					state_q <= FSM_FINISH;
				end
				FSM_FINISH: begin
					if (!m_tvalid_q || m_tready) begin
						state_q <= FSM_IDLE;
					end
				end
				default: begin
					state_q <= FSM_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			FSM_IDLE: begin
				if (accept) begin
					cmd_q   <= cmd_in;
					value_q <= value_in;
					chk_q   <= '0;
					if (cmd_in == CMD_INSERT) begin
						status_q <= full ? STAT_FULL : STAT_DONE;
					end else if (cmd_in == CMD_SEARCH || cmd_in == CMD_DELETE) begin
						status_q <= (count_q == '0) ? STAT_MISSING : STAT_DONE;
					end else begin
						status_q <= STAT_DONE;
					end
				end
			end
			FSM_SCAN: begin
				if (hit) begin
					status_q <= STAT_DONE;
				end else if (more) begin
					chk_q <= IDX_W'(nxt_chk);
				end else begin
					status_q <= STAT_MISSING;
				end
			end
			FSM_FINISH: begin
				if (!m_tvalid_q || m_tready) begin
					out_status_q <= status_q;
					out_count_q  <= count_ext[ENTRY_COUNT_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(M_TDATA_W - STATUS_W - ENTRY_COUNT_W){1'b0}}, out_count_q, out_status_q};

	`UVT_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1,
		count_q <= CNT_W'(TABLE_DEPTH), "live count above table depth")
	`UVT_ASSERT_NOW(a_one_port_op, clk, arst_n, 1'b1,
		!(ram_ctl.wr_en && ram_ctl.rd_en), "memory read and write in the same cycle")
	`UVT_ASSERT_NEXT(a_insert_grows, clk, arst_n, accept && cmd_in == CMD_INSERT && !full,
		count_q == $past(count_q) + CNT_W'(1), "insert did not raise the count")
	`UVT_ASSERT_NOW(a_scan_nonempty, clk, arst_n, state_q == FSM_SCAN || state_q == FSM_SWAP,
		count_q != '0, "scan or swap on an empty table")

endmodule

/* tb/unordered_value_table_checker.sv */
// Checker for the unordered value table: watches both streams, predicts each response and compares it.
`timescale 1ns / 100ps

module unordered_value_table_checker #(
	parameter int TABLE_DEPTH = uvt_pkg::DEF_TABLE_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [uvt_pkg::VALUE_W-1:0]   s_tdata,         // [31:0] value
	input  logic [uvt_pkg::CMD_W-1:0]     s_tuser,         // [1:0] command
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [uvt_pkg::M_TDATA_W-1:0] m_tdata,         // [1:0] status, [6:2] entry_count
	output int                            fail_count,
	output int                            pending_replies
);
	import uvt_pkg::*;

	typedef struct packed {
		status_t                  status;
		logic [ENTRY_COUNT_W-1:0] entry_count;
	} table_reply_t;

	logic [VALUE_W-1:0] stored_values [TABLE_DEPTH];
	int                 live_entries;
	table_reply_t       expected_replies [$];
	int                 mismatches = 0;

	assign fail_count = mismatches;

	// Applies one request to the shadow table and returns the response it must produce.
	function automatic table_reply_t apply_table_command(input cmd_t cmd,
			input logic [VALUE_W-1:0] value);
		table_reply_t reply;
		int           hit;
		hit = -1;
		reply.status = STAT_DONE;
		if (cmd == CMD_SEARCH || cmd == CMD_DELETE) begin
			for (int i = 0; i < live_entries; i++) begin
				if (hit < 0 && stored_values[i] == value)
					hit = i;
			end
		end
		case (cmd)
			CMD_INSERT: begin
				if (live_entries >= TABLE_DEPTH) begin
					reply.status = STAT_FULL;
				end else begin
					stored_values[live_entries] = value;
					live_entries++;
				end
			end
			CMD_SEARCH: begin
				if (hit < 0)
					reply.status = STAT_MISSING;
			end
			CMD_DELETE: begin
				if (hit < 0) begin
					reply.status = STAT_MISSING;
				end else begin
					// The last live entry fills the hole; deleting the last one copies onto itself.
					stored_values[hit] = stored_values[live_entries - 1];
					live_entries--;
				end
			end
			default: ;
		endcase
		reply.entry_count = live_entries[ENTRY_COUNT_W-1:0];
		return reply;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		table_reply_t seen;
		table_reply_t want;
		if (!arst_n) begin
			live_entries = 0;
			expected_replies.delete();
			pending_replies <= 0;
		end else begin
			if (s_tvalid && s_tready)
				expected_replies.insert(expected_replies.size(),
					apply_table_command(s_tuser, s_tdata));
			if (m_tvalid && m_tready) begin
				seen.status      = m_tdata[STATUS_W-1:0];
				seen.entry_count = m_tdata[STATUS_W +: ENTRY_COUNT_W];
				if (expected_replies.size() == 0) begin
					$error("response with no request outstanding: status %0d, entry_count %0d",
						seen.status, seen.entry_count);
					mismatches++;
				end else begin
					want = expected_replies.pop_front();
					if (seen.status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, seen.status);
						mismatches++;
					end
					if (seen.entry_count !== want.entry_count) begin
						$error("entry_count: expected %0d, actual %0d",
							want.entry_count, seen.entry_count);
						mismatches++;
					end
				end
			end
			pending_replies <= expected_replies.size();
		end
	end

endmodule

/* tb/unordered_value_table_top_tb.sv */
// Testbench top of the unordered value table: clock, reset, request and response traffic, verdict.
`timescale 1ns / 100ps

module unordered_value_table_top_tb;
	import uvt_pkg::*;

	localparam int   DEPTH         = DEF_TABLE_DEPTH;
	localparam cmd_t CMD_UNUSED    = 2'd3;
	localparam int   RANDOM_COUNT  = 1025;
	localparam int   HOLD_AT       = 300;
	localparam int   DRAIN_AT      = 600;
	localparam int   HOLD_CYCLES   = 400;
	localparam int   SETTLE_CYCLES = 25;
	localparam int   STALL_LIMIT   = 2000;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [VALUE_W-1:0]   s_tdata = '0;
	logic [CMD_W-1:0]     s_tuser = CMD_INSERT;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 hold_request = 1'b0;
	int                   fail_count;
	int                   pending_replies;
	int                   burst_left = 0;
	int                   idle_cycles = 0;

	unordered_value_table_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	unordered_value_table_checker #(.TABLE_DEPTH(DEPTH)) i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.fail_count      (fail_count),
		.pending_replies (pending_replies)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Receiver: the stall pattern is redrawn at random as the run goes on, and one long hold-off is taken on request.
	always @(posedge clk) begin
		static int pattern = 0;
		static int phase = 0;
		static int hold_left = 0;
		static bit hold_taken = 1'b0;
		logic ready;
		if (hold_request && !hold_taken) begin
			hold_taken = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		phase++;
		if (phase % 50 == 0)
			pattern = $urandom_range(0, 3);
		case (pattern)
			0: ready = 1'b1;
			1: ready = 1'($urandom_range(0, 1));
			2: ready = ($urandom_range(0, 3) == 0);
			default: ready = phase[1];
		endcase
		if (hold_left > 0) begin
			hold_left--;
			ready = 1'b0;
		end
		m_tready <= ready;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("unordered_value_table_top: mismatch");
				$finish;
			end
		end
	end

	// Offers one request, with random gaps between bursts, and returns at the accepting edge.
	task automatic issue_request(input cmd_t cmd, input logic [VALUE_W-1:0] value);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
				: $urandom_range(1, 20);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= value;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic wait_for_replies;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_replies != 0) @(posedge clk);
	endtask

	initial begin
		logic [VALUE_W-1:0] pool [8];
		int                 mode;
		int                 roll;
		cmd_t               cmd;
		logic [VALUE_W-1:0] value;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Empty table: nothing to find or remove, and the unused code only reports the count.
		issue_request(CMD_DELETE, 32'd5);
		issue_request(CMD_SEARCH, 32'd0);
		issue_request(CMD_UNUSED, 32'hdead_beef);
		issue_request(CMD_INSERT, 32'h8000_0000);
		issue_request(CMD_INSERT, 32'h7fff_ffff);
		issue_request(CMD_INSERT, 32'hffff_ffff);
		issue_request(CMD_INSERT, 32'h0000_0000);
		issue_request(CMD_INSERT, 32'h0000_0001);
		issue_request(CMD_SEARCH, 32'h7fff_ffff);
		issue_request(CMD_SEARCH, 32'h7fff_fffe);
		// Removing the first entry pulls the last one into slot zero.
		issue_request(CMD_DELETE, 32'h8000_0000);
		// The entry at the end is removed onto itself.
		issue_request(CMD_DELETE, 32'h0000_0000);
		issue_request(CMD_DELETE, 32'h1234_5678);
		for (int i = 0; i < 13; i++)
			issue_request(CMD_INSERT, 32'd7 + i[VALUE_W-1:0] % 5);
		issue_request(CMD_INSERT, 32'h5555_aaaa);
		issue_request(CMD_UNUSED, 32'h0);
		issue_request(CMD_DELETE, 32'd7);
		wait_for_replies();

		for (int n = 0; n < RANDOM_COUNT; n++) begin
			if (n % 40 == 0) begin
				mode = $urandom_range(0, 2);
				foreach (pool[k]) begin
					case ($urandom_range(0, 3))
						0: pool[k] = $urandom();
						1: pool[k] = $urandom_range(0, 9);
						2: pool[k] = {$urandom_range(0, 1) ? 2'b10 : 2'b01, 30'h0} - 1'b1;
						default: pool[k] = -$urandom_range(1, 4);
					endcase
				end
			end
			roll = $urandom_range(0, 99);
			// Fill-heavy, drain-heavy and balanced stretches walk the count between its ends.
			case (mode)
				0: cmd = (roll < 60) ? CMD_INSERT : (roll < 80) ? CMD_SEARCH
					: (roll < 96) ? CMD_DELETE : CMD_UNUSED;
				1: cmd = (roll < 20) ? CMD_INSERT : (roll < 40) ? CMD_SEARCH
					: (roll < 96) ? CMD_DELETE : CMD_UNUSED;
				default: cmd = (roll < 35) ? CMD_INSERT : (roll < 65) ? CMD_SEARCH
					: (roll < 96) ? CMD_DELETE : CMD_UNUSED;
			endcase
			value = ($urandom_range(0, 9) < 7) ? pool[$urandom_range(0, 7)] : $urandom();
			if (n == HOLD_AT)
				hold_request <= 1'b1;
			if (n == DRAIN_AT)
				wait_for_replies();
			issue_request(cmd, value);
		end

		wait_for_replies();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_replies == 0)
			$display("unordered_value_table_top: match");
		else
			$display("unordered_value_table_top: mismatch");
		$finish;
	end

endmodule
